// File: rtl/core/i2cbm_pkg.sv
package i2cbm_pkg;

    localparam int HOLD_W = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd720;

    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_STOP     = 3'd1,
        ACT_WRITE    = 3'd2,
        ACT_READ     = 3'd3,
        ACT_SEND_ACK = 3'd4,
        ACT_RECV_ACK = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_HOLD
    } eng_state_t;

endpackage

// File: rtl/core/i2cbm_cmd_if.sv
interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic [7:0] sda_samples;

    modport source (output valid, action, tx_byte, ack_level, sda_samples, input ready);
    modport sink (input valid, action, tx_byte, ack_level, sda_samples, output ready);
endinterface

// File: rtl/core/i2cbm_step_if.sv
interface i2cbm_step_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last_step;

    modport source (output valid, scl_level, sda_level, rx_byte, ack_seen, last_step,
                    input ready);
    modport sink (input valid, scl_level, sda_level, rx_byte, ack_seen, last_step,
                  output ready);
endinterface

// File: rtl/core/i2cbm_hold_timer.sv
module i2cbm_hold_timer
    import i2cbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [HOLD_W-1:0] cfg_wdata,
    input  logic              start,
    output logic              done
);

    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] cnt_reg;
    logic [HOLD_W-1:0] cnt_next;

    // a zero hold value behaves the same as a hold value of 1
    assign done = (cnt_reg <= HOLD_W'(1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = hold_reg;
        end
        else if (!done)
        begin
            cnt_next = cnt_reg - HOLD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                hold_reg <= cfg_wdata;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/i2cbm_bit_engine.sv
module i2cbm_bit_engine
    import i2cbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    i2cbm_cmd_if.sink   cmd,
    i2cbm_step_if.source step,
    output logic      tmr_start,
    input  logic      tmr_done
);

    eng_state_t state_reg, state_next;
    action_t    act_reg;
    logic [1:0] phase_reg, phase_n;
    logic [2:0] bit_reg, bit_n;
    logic [7:0] tx_reg;
    logic [7:0] smp_reg;
    logic [7:0] rx_reg;
    logic       ack_reg;
    logic       scl_reg, sda_reg;
    logic       done_reg;

    logic       ovalid_reg;
    logic       oscl_reg, osda_reg, oack_reg, olast_reg;
    logic [7:0] orx_reg;

    logic       scl_n, sda_n, last_n, ack_out;
    logic [7:0] rx_out;
    logic       tx_shift, take_sample;
    logic       cmd_acc, act_ok, slot_free, emit;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign act_ok     = (cmd.action <= 3'(ACT_RECV_ACK));
    assign slot_free  = !ovalid_reg || step.ready;
    assign emit       = (state_reg == ST_EMIT) && slot_free;

    assign tmr_start = emit;

    assign step.valid     = ovalid_reg;
    assign step.scl_level = oscl_reg;
    assign step.sda_level = osda_reg;
    assign step.rx_byte   = orx_reg;
    assign step.ack_seen  = oack_reg;
    assign step.last_step = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && act_ok)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (tmr_done)
                begin
                    state_next = done_reg ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pin step for the current phase
    always_comb
    begin
        scl_n       = scl_reg;
        sda_n       = sda_reg;
        last_n      = 1'b0;
        rx_out      = '0;
        ack_out     = 1'b0;
        phase_n     = phase_reg + 2'd1;
        bit_n       = bit_reg;
        tx_shift    = 1'b0;
        take_sample = 1'b0;
        unique case (act_reg)
            ACT_START:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = 1'b1;
                    2'd1: scl_n = 1'b1;
                    2'd2: sda_n = 1'b0;
                    default:
                    begin
                        scl_n  = 1'b0;
                        last_n = 1'b1;
                    end
                endcase
            end
            ACT_STOP:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = 1'b0;
                    2'd1: scl_n = 1'b1;
                    default:
                    begin
                        sda_n  = 1'b1;
                        last_n = 1'b1;
                    end
                endcase
            end
            ACT_WRITE:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = tx_reg[7];
                    2'd1: scl_n = 1'b1;
                    default:
                    begin
                        scl_n    = 1'b0;
                        tx_shift = 1'b1;
                        phase_n  = 2'd0;
                        bit_n    = bit_reg + 3'd1;
                        last_n   = (bit_reg == 3'd7);
                    end
                endcase
            end
            ACT_READ:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = 1'b1;
                    2'd1:
                    begin
                        scl_n       = 1'b1;
                        take_sample = 1'b1;
                    end
                    default:
                    begin
                        scl_n   = 1'b0;
                        phase_n = 2'd1;
                        bit_n   = bit_reg + 3'd1;
                        last_n  = (bit_reg == 3'd7);
                        rx_out  = last_n ? rx_reg : 8'd0;
                    end
                endcase
            end
            ACT_SEND_ACK:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = ack_reg;
                    2'd1: scl_n = 1'b1;
                    default:
                    begin
                        scl_n  = 1'b0;
                        last_n = 1'b1;
                    end
                endcase
            end
            ACT_RECV_ACK:
            begin
                unique case (phase_reg)
                    2'd0: sda_n = 1'b1;
                    2'd1:
                    begin
                        scl_n       = 1'b1;
                        take_sample = 1'b1;
                    end
                    default:
                    begin
                        scl_n   = 1'b0;
                        last_n  = 1'b1;
                        ack_out = ack_reg;
                    end
                endcase
            end
            default:
            begin
                last_n = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            done_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            phase_reg  <= '0;
            bit_reg    <= '0;
            act_reg    <= ACT_START;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_acc)
            begin
                act_reg   <= action_t'(cmd.action);
                phase_reg <= '0;
                bit_reg   <= '0;
                done_reg  <= 1'b0;
            end
            else if (emit)
            begin
                scl_reg   <= scl_n;
                sda_reg   <= sda_n;
                phase_reg <= phase_n;
                bit_reg   <= bit_n;
                done_reg  <= last_n;
            end
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (step.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            tx_reg  <= cmd.tx_byte;
            smp_reg <= cmd.sda_samples;
            ack_reg <= cmd.ack_level;
            rx_reg  <= '0;
        end
        else if (emit)
        begin
            if (tx_shift)
            begin
                tx_reg <= {tx_reg[6:0], 1'b0};
            end
            if (take_sample)
            begin
                rx_reg  <= {rx_reg[6:0], smp_reg[7]};
                smp_reg <= {smp_reg[6:0], 1'b0};
                if (act_reg == ACT_RECV_ACK)
                begin
                    ack_reg <= smp_reg[7];
                end
            end
        end
        if (emit)
        begin
            oscl_reg  <= scl_n;
            osda_reg  <= sda_n;
            orx_reg   <= rx_out;
            oack_reg  <= ack_out;
            olast_reg <= last_n;
        end
    end

endmodule

// File: rtl/core/i2c_bit_level_master_unit.sv
// I2C bit-level master.
// cmd channel (valid/ready): one word per command: action, tx_byte,
//   ack_level, sda_samples. Actions 6 and 7 are taken and dropped.
// step channel (valid/ready): one word per SCL/SDA pin write; last_step
//   marks the final step. rx_byte and ack_seen are nonzero only on the
//   last step of read byte and receive ack.
// cfg_we/cfg_wdata: writes step_hold_cycles (reset 720); write while idle.
// Commands expand to 4, 3, 24, 17, 3 or 3 steps. Each step is produced
//   in the EMIT state, once the previous step's hold has ended and the
//   step output slot is free, and is then held by the hold counter,
//   which loads step_hold_cycles; a value of 0 acts as 1.
// Bits move one per SCL pulse through the tx and sample shift registers.
// A new command is taken in the cycle after the hold of the previous
//   command's last step ends.
// The step output is registered; while the sink stalls, the next step
//   waits in the engine and the hold counter does not restart.
// Reset: SCL and SDA drive released (1), engine idle, hold 720.
module i2c_bit_level_master_unit
    import i2cbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    i2cbm_cmd_if.sink         cmd,
    i2cbm_step_if.source      step,
    input  logic              cfg_we,
    input  logic [HOLD_W-1:0] cfg_wdata
);

    logic tmr_start;
    logic tmr_done;

    i2cbm_bit_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .step      (step),
        .tmr_start (tmr_start),
        .tmr_done  (tmr_done)
    );

    i2cbm_hold_timer u_timer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (tmr_start),
        .done      (tmr_done)
    );

endmodule

// File: bench/i2cbm_step_checker.sv
module i2cbm_step_checker
    import i2cbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    i2cbm_cmd_if              cmd,
    i2cbm_step_if             step,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx;
        logic       ack;
        logic       last;
    } pin_step_t;

    pin_step_t         steps_due[$];
    logic              scl_q;
    logic              sda_q;
    logic [7:0]        tx_shift;
    logic [7:0]        rx_acc;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic pin_write(input logic on_scl, input logic lvl);
        pin_step_t s;
        if (on_scl)
            scl_q = lvl;
        else
            sda_q = lvl;
        s = '0;
        s.scl = scl_q;
        s.sda = sda_q;
        steps_due.push_back(s);
    endtask

    task automatic expand_cmd(input logic [2:0] act, input logic [7:0] tx,
                              input logic ackl, input logic [7:0] samples);
        pin_step_t s;
        logic [7:0] acc;
        logic       ack_bit;
        acc = '0;
        ack_bit = 1'b0;
        case (act)
            ACT_START:
            begin
                pin_write(1'b0, 1'b1);
                pin_write(1'b1, 1'b1);
                pin_write(1'b0, 1'b0);
                pin_write(1'b1, 1'b0);
            end
            ACT_STOP:
            begin
                pin_write(1'b0, 1'b0);
                pin_write(1'b1, 1'b1);
                pin_write(1'b0, 1'b1);
            end
            ACT_WRITE:
            begin
                tx_shift = tx;
                for (int i = 0; i < 8; i++)
                begin
                    pin_write(1'b0, tx_shift[7]);
                    pin_write(1'b1, 1'b1);
                    pin_write(1'b1, 1'b0);
                    tx_shift = tx_shift << 1;
                end
            end
            ACT_READ:
            begin
                pin_write(1'b0, 1'b1);
                for (int i = 0; i < 8; i++)
                begin
                    pin_write(1'b1, 1'b1);
                    acc[7-i] = samples[7-i];
                    pin_write(1'b1, 1'b0);
                end
                rx_acc = acc;
            end
            ACT_SEND_ACK:
            begin
                pin_write(1'b0, ackl);
                pin_write(1'b1, 1'b1);
                pin_write(1'b1, 1'b0);
            end
            ACT_RECV_ACK:
            begin
                pin_write(1'b0, 1'b1);
                pin_write(1'b1, 1'b1);
                ack_bit = samples[7];
                pin_write(1'b1, 1'b0);
            end
            default:
                return;
        endcase
        s = steps_due.pop_back();
        s.last = 1'b1;
        if (act == ACT_READ)
            s.rx = rx_acc;
        if (act == ACT_RECV_ACK)
            s.ack = ack_bit;
        steps_due.push_back(s);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: step %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_step_t want;
        if (!rst_n)
        begin
            steps_due.delete();
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            tx_shift   = '0;
            rx_acc     = '0;
        end
        else
        begin
            if (step.valid && step.ready)
            begin
                if (steps_due.size() == 0)
                begin
                    $display("%0t: step word with none due: scl=%b sda=%b rx=%h ack=%b last=%b",
                             $time, step.scl_level, step.sda_level, step.rx_byte,
                             step.ack_seen, step.last_step);
                    fail_count++;
                end
                else
                begin
                    want = steps_due.pop_front();
                    check_field("scl_level", 8'(want.scl), 8'(step.scl_level));
                    check_field("sda_level", 8'(want.sda), 8'(step.sda_level));
                    check_field("rx_byte", want.rx, step.rx_byte);
                    check_field("ack_seen", 8'(want.ack), 8'(step.ack_seen));
                    check_field("last_step", 8'(want.last), 8'(step.last_step));
                end
            end
            if (cmd.valid && cmd.ready)
                expand_cmd(cmd.action, cmd.tx_byte, cmd.ack_level, cmd.sda_samples);
        end
        pending = steps_due.size();
    end

endmodule

// File: bench/i2c_bit_level_master_unit_tb.sv
module i2c_bit_level_master_unit_tb;
    import i2cbm_pkg::*;

    localparam int         STALL_LIMIT     = 300000;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [2:0] ACT_UNDEF_LO    = 3'd6;
    localparam logic [2:0] ACT_UNDEF_HI    = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [HOLD_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                hold_now;
    int                quiet_cycles;
    bit                src_idle_en;
    bit                snk_idle_en;
    bit                hold_off_req;

    i2cbm_cmd_if  cmd ();
    i2cbm_step_if step ();

    i2c_bit_level_master_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .step      (step),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2cbm_step_checker step_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .step       (step),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // step sink: random stalls, plus one long hold-off on request
    initial
    begin
        step.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                step.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            step.ready <= !(snk_idle_en && $urandom_range(99) < 24);
            @(negedge clk);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (step.valid && step.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[i2c_bit_level_master_unit] ERROR");
        $finish;
    end

    // called and returns at a falling edge; valid stays up until the next word or settle
    task automatic send_cmd(input logic [2:0] act, input logic [7:0] tx,
                            input logic ackl, input logic [7:0] samples);
        while (src_idle_en && $urandom_range(99) < 24)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.action      <= act;
        cmd.tx_byte     <= tx;
        cmd.ack_level   <= ackl;
        cmd.sda_samples <= samples;
        do
            @(posedge clk);
        while (!(cmd.valid && cmd.ready));
        @(negedge clk);
    endtask

    task automatic send_rand(input logic [2:0] act);
        send_cmd(act, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)));
    endtask

    task automatic settle();
        int held;
        cmd.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        held = (hold_now < 1) ? 1 : hold_now;
        repeat (2 * (held + 2) + 10) @(negedge clk);
    endtask

    task automatic set_hold(input logic [HOLD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        hold_now  = value;
    endtask

    // mostly framed transfers with random content, some stray commands
    task automatic random_traffic(input int n_words);
        int         sent;
        logic [2:0] act;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(9) == 0)
            begin
                act = 3'($urandom_range(7));
                send_rand(act);
                if (act <= ACT_RECV_ACK)
                    sent++;
            end
            else
            begin
                send_rand(ACT_START);
                send_rand(ACT_WRITE);
                send_rand(ACT_RECV_ACK);
                sent += 3;
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(1))
                    begin
                        send_rand(ACT_READ);
                        send_rand(ACT_SEND_ACK);
                    end
                    else
                    begin
                        send_rand(ACT_WRITE);
                        send_rand(ACT_RECV_ACK);
                    end
                    sent += 2;
                end
                // sometimes leave the bus open for a repeated start
                if ($urandom_range(7) != 0)
                begin
                    send_rand(ACT_STOP);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        cmd.valid       = 1'b0;
        cmd.action      = ACT_START;
        cmd.tx_byte     = '0;
        cmd.ack_level   = 1'b0;
        cmd.sda_samples = '0;
        src_idle_en     = 1'b1;
        snk_idle_en     = 1'b1;
        hold_off_req    = 1'b0;
        hold_now        = HOLD_RESET;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_rand(ACT_START);
        send_rand(ACT_RECV_ACK);
        settle();

        set_hold('0);
        send_cmd(ACT_START, 8'hFF, 1'b1, 8'hFF);
        send_cmd(ACT_WRITE, 8'h00, 1'b1, 8'hFF);
        send_cmd(ACT_RECV_ACK, 8'h00, 1'b0, 8'h80);
        send_cmd(ACT_WRITE, 8'hFF, 1'b0, 8'h00);
        send_cmd(ACT_RECV_ACK, 8'hFF, 1'b1, 8'h7F);
        send_cmd(ACT_WRITE, 8'hA5, 1'b0, 8'h5A);
        send_cmd(ACT_READ, 8'hFF, 1'b1, 8'h00);
        send_cmd(ACT_SEND_ACK, 8'h00, 1'b0, 8'hFF);
        send_cmd(ACT_READ, 8'h00, 1'b0, 8'hFF);
        send_cmd(ACT_SEND_ACK, 8'hFF, 1'b1, 8'h00);
        send_cmd(ACT_READ, 8'h3C, 1'b1, 8'h5A);
        send_cmd(ACT_UNDEF_LO, 8'hFF, 1'b1, 8'hFF);
        send_cmd(ACT_UNDEF_HI, 8'h00, 1'b0, 8'h00);
        send_cmd(ACT_STOP, 8'h00, 1'b1, 8'hFF);
        send_cmd(ACT_START, 8'h00, 1'b0, 8'h00);
        send_cmd(ACT_WRITE, 8'h01, 1'b1, 8'h80);
        send_cmd(ACT_RECV_ACK, 8'h80, 1'b0, 8'hFF);
        send_cmd(ACT_STOP, 8'hFF, 1'b0, 8'h00);
        send_cmd(ACT_STOP, 8'h00, 1'b1, 8'h00);
        settle();

        set_hold(16'd1);
        hold_off_req = 1'b1;
        random_traffic(35);
        settle();

        set_hold(16'hFFFF);
        send_rand(ACT_STOP);
        settle();

        set_hold(16'd2);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        random_traffic(20);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        random_traffic(20);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("[i2c_bit_level_master_unit] OK");
        else
            $display("[i2c_bit_level_master_unit] ERROR");
        $finish;
    end

endmodule
